// ===== hdl/rwu_pkg.sv =====
// Shared constants, types and helper functions for the RMSprop weight update block.
package rwu_pkg;

    localparam int unsigned ENTRIES_DEF = 4096;
    localparam int IDX_W   = 12;
    localparam int DATA_W  = 32;
    localparam int CACHE_W = 48;

    localparam logic [31:0] LEARN_RATE_RST   = 32'd42949673;
    localparam logic [31:0] DECAY_RST        = 32'd4290672329;
    localparam logic [30:0] CLIP_LIMIT_RST   = 31'd83886080;
    localparam logic [31:0] REG_STRENGTH_RST = 32'd281475;
    localparam logic [15:0] EPSILON_RST      = 16'd43;

    typedef enum logic [2:0] {
        REG_LEARN_RATE   = 3'd0,
        REG_DECAY        = 3'd1,
        REG_CLIP_LIMIT   = 3'd2,
        REG_REG_STRENGTH = 3'd3,
        REG_EPSILON      = 3'd4
    } reg_addr_t;

    // root pipeline: 64-bit radicand, 2 result bits per stage
    localparam int SQ_IN_W  = 64;
    localparam int ROOT_W   = 32;
    localparam int SQ_STEPS = 2;
    localparam int SQ_N     = SQ_IN_W / (2 * SQ_STEPS);

    // divide pipeline: 34 quotient bits, 2 per stage
    localparam int NQ_W     = 54;
    localparam int STEP_W   = 34;
    localparam int DV_STEPS = 2;
    localparam int DV_N     = STEP_W / DV_STEPS;

    typedef struct packed {
        logic [ROOT_W+1:0] rem;
        logic [ROOT_W-1:0] root;
    } sq_acc_t;

    typedef struct packed {
        logic [ROOT_W-1:0] rem;
        logic [STEP_W-1:0] quo;
    } dv_acc_t;

    // partial index reduction: six restoring steps from shift base+5 down to base
    function automatic logic [IDX_W-1:0] idx_reduce(input logic [IDX_W-1:0] x,
                                                    input int unsigned entries,
                                                    input int unsigned base);
        logic [IDX_W-1:0] r;
        logic [63:0] d;
        r = x;
        for (int i = 5; i >= 0; i--) begin
            d = 64'(entries) << (base + 32'(i));
            if (d < 64'(2 ** IDX_W) && 64'(r) >= d) begin
                r = r - d[IDX_W-1:0];
            end
        end
        return r;
    endfunction

    function automatic sq_acc_t sq_step(input sq_acc_t a, input logic [1:0] b);
        sq_acc_t o;
        logic [ROOT_W+3:0] rem_sh;
        logic [ROOT_W+3:0] trial;
        rem_sh = {a.rem, b};
        trial  = {2'b00, a.root, 2'b01};
        if (rem_sh >= trial) begin
            o.rem  = (ROOT_W+2)'(rem_sh - trial);
            o.root = {a.root[ROOT_W-2:0], 1'b1};
        end else begin
            o.rem  = (ROOT_W+2)'(rem_sh);
            o.root = {a.root[ROOT_W-2:0], 1'b0};
        end
        return o;
    endfunction

    function automatic dv_acc_t dv_step(input dv_acc_t a, input logic [ROOT_W-1:0] dvs,
                                        input logic b);
        dv_acc_t o;
        logic [ROOT_W:0] sh;
        sh = {a.rem, b};
        if (sh >= {1'b0, dvs}) begin
            o.rem = ROOT_W'(sh - {1'b0, dvs});
            o.quo = {a.quo[STEP_W-2:0], 1'b1};
        end else begin
            o.rem = ROOT_W'(sh);
            o.quo = {a.quo[STEP_W-2:0], 1'b0};
        end
        return o;
    endfunction

endpackage

// ===== hdl/rwu_ram.sv =====
// Simple dual-port RAM, one write port and one registered read port.
module rwu_ram #(
    parameter int WIDTH = rwu_pkg::CACHE_W,
    parameter int DEPTH = rwu_pkg::ENTRIES_DEF,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/rmsprop_weight_update.sv =====
// RMSprop weight update: per-element squared-gradient cache and weight step pipeline.
//
// Input stream (s_*): one beat per parameter element: index, weight and gradient in
// s_tdata, the fresh-entry flag in s_tuser. Result stream (m_*): one beat per input
// beat, in order: new weight in m_tdata, clipped flag in m_tuser.
// Registers sit on the APB port; the user must write them only while the block is
// idle, as the block itself does not enforce it. Throughput is one beat per cycle
// unless a beat waits on an index match or m_tready stalls. A beat whose index
// matches an element still in the cache update stages (four stages, read to
// write-back) waits until that write has landed; beats flagged fresh never wait.
// From input beat to result valid the path runs through five arithmetic stages,
// sixteen square-root stages (two root bits each) and seventeen divide stages (two
// quotient bits each), then a two-entry output buffer.
// After reset the cache store is swept to zero, one entry per cycle, over all ENTRIES entries;
// s_tready stays low meanwhile. A stall on m_tready fills the output buffer and then
// freezes the whole pipeline; nothing is dropped or repeated.
module rmsprop_weight_update #(
    parameter int unsigned ENTRIES = rwu_pkg::ENTRIES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // elem_index[11:0], weight_in[43:12], grad_in[75:44]
    input  logic [0:0]  s_tuser,   // fresh_entry[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // weight_out[31:0]
    output logic [0:0]  m_tuser,   // was_clipped[0]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int IDX_W  = rwu_pkg::IDX_W;
    localparam int CW     = rwu_pkg::CACHE_W;
    localparam int SQ_N   = rwu_pkg::SQ_N;
    localparam int DV_N   = rwu_pkg::DV_N;
    localparam int STEP_W = rwu_pkg::STEP_W;
    localparam int NQ_W   = rwu_pkg::NQ_W;
    localparam int ROOT_W = rwu_pkg::ROOT_W;
    localparam int SQ_IN_W = rwu_pkg::SQ_IN_W;

    typedef struct packed {
        logic [31:0]     w;
        logic            gneg;
        logic            clip;
        logic [15:0]     regm;
        logic [NQ_W-1:0] nq;
    } sq_pl_t;

    typedef struct packed {
        logic [31:0]       w;
        logic              gneg;
        logic              clip;
        logic [15:0]       regm;
        logic [ROOT_W-1:0] dvs;
        logic              ovf;
    } dv_pl_t;

    // configuration
    logic [31:0] learn_rate_reg;
    logic [31:0] decay_reg;
    logic [30:0] clip_limit_reg;
    logic [31:0] reg_strength_reg;
    logic [15:0] epsilon_reg;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            learn_rate_reg   <= rwu_pkg::LEARN_RATE_RST;
            decay_reg        <= rwu_pkg::DECAY_RST;
            clip_limit_reg   <= rwu_pkg::CLIP_LIMIT_RST;
            reg_strength_reg <= rwu_pkg::REG_STRENGTH_RST;
            epsilon_reg      <= rwu_pkg::EPSILON_RST;
        end else if (psel && penable && pwrite && pready) begin
            case (paddr[4:2])
                rwu_pkg::REG_LEARN_RATE:   learn_rate_reg   <= pwdata;
                rwu_pkg::REG_DECAY:        decay_reg        <= pwdata;
                rwu_pkg::REG_CLIP_LIMIT:   clip_limit_reg   <= pwdata[30:0];
                rwu_pkg::REG_REG_STRENGTH: reg_strength_reg <= pwdata;
                rwu_pkg::REG_EPSILON:      epsilon_reg      <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            rwu_pkg::REG_LEARN_RATE:   prdata = learn_rate_reg;
            rwu_pkg::REG_DECAY:        prdata = decay_reg;
            rwu_pkg::REG_CLIP_LIMIT:   prdata = {1'b0, clip_limit_reg};
            rwu_pkg::REG_REG_STRENGTH: prdata = reg_strength_reg;
            rwu_pkg::REG_EPSILON:      prdata = {16'd0, epsilon_reg};
            default:                   prdata = 32'd0;
        endcase
    end

    // cache clearing sweep after reset
    logic          clr_busy_reg;
    logic [AW-1:0] clr_cnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end else if (clr_busy_reg) begin
            clr_cnt_reg <= clr_cnt_reg + AW'(1);
            if (clr_cnt_reg == AW'(ENTRIES - 1)) begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    // output buffer occupancy gates the pipeline
    logic [1:0] ocnt_reg;
    logic       en;
    assign en = (ocnt_reg != 2'd2);

    // stage 1: input register
    logic             v1_reg;
    logic [IDX_W-1:0] idx1_reg;
    logic [31:0]      w1_reg;
    logic [31:0]      g1_reg;
    logic             fresh1_reg;
    logic [IDX_W-1:0] idx_red1;
    logic             haz;
    logic             mv1;
    logic             acc_in;

    logic             v2_reg, v3_reg, v4_reg, v5_reg;
    logic [IDX_W-1:0] idx2_reg, idx3_reg, idx4_reg, idx5_reg;

    assign idx_red1 = rwu_pkg::idx_reduce(idx1_reg, ENTRIES, 32'd0);
    assign haz = v1_reg && !fresh1_reg &&
                 ((v2_reg && idx2_reg == idx_red1) || (v3_reg && idx3_reg == idx_red1) ||
                  (v4_reg && idx4_reg == idx_red1) || (v5_reg && idx5_reg == idx_red1));
    assign mv1      = en && v1_reg && !haz;
    assign s_tready = en && !clr_busy_reg && (!v1_reg || !haz);
    assign acc_in   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (acc_in) begin
            v1_reg <= 1'b1;
        end else if (mv1) begin
            v1_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (acc_in) begin
            idx1_reg   <= rwu_pkg::idx_reduce(s_tdata[11:0], ENTRIES, 32'd6);
            w1_reg     <= s_tdata[43:12];
            g1_reg     <= s_tdata[75:44];
            fresh1_reg <= s_tuser[0];
        end
    end

    logic [31:0] gmag1, wm1, neg_lim1, lim1;
    logic        gt1, lt1;
    logic [30:0] gcm1;

    always_comb begin
        gmag1    = g1_reg[31] ? (~g1_reg + 32'd1) : g1_reg;
        wm1      = w1_reg[31] ? (~w1_reg + 32'd1) : w1_reg;
        lim1     = {1'b0, clip_limit_reg};
        neg_lim1 = ~lim1 + 32'd1;
        gt1      = $signed(g1_reg) > $signed(lim1);
        lt1      = $signed(g1_reg) < $signed(neg_lim1);
        gcm1     = (gt1 || lt1) ? clip_limit_reg : gmag1[30:0];
    end

    // cache store
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [CW-1:0] ram_wdata;
    logic [CW-1:0] ram_rdata;
    logic [CW-1:0] nc5_reg;

    assign ram_we    = clr_busy_reg || (en && v5_reg);
    assign ram_waddr = clr_busy_reg ? clr_cnt_reg : AW'(idx5_reg);
    assign ram_wdata = clr_busy_reg ? '0 : nc5_reg;

    rwu_ram #(
        .WIDTH (CW),
        .DEPTH (ENTRIES)
    ) u_cache (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (mv1),
        .raddr (AW'(idx_red1)),
        .rdata (ram_rdata)
    );

    // stage 2: cache data arrives, first products
    logic [31:0] w2_reg, gmag2_reg, wm2_reg;
    logic [30:0] gcm2_reg;
    logic        gneg2_reg, clip2_reg, fresh2_reg;
    logic [CW-1:0] cache2;
    logic [47:0]   pch2;
    logic [63:0]   pcl2, g2_2, regp2;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= mv1;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            idx2_reg   <= idx_red1;
            w2_reg     <= w1_reg;
            gmag2_reg  <= gmag1;
            wm2_reg    <= wm1;
            gcm2_reg   <= gcm1;
            gneg2_reg  <= g1_reg[31];
            clip2_reg  <= gt1 || lt1;
            fresh2_reg <= fresh1_reg;
        end
    end

    always_comb begin
        cache2 = fresh2_reg ? '0 : ram_rdata;
        pch2   = cache2[47:32] * decay_reg;
        pcl2   = cache2[31:0] * decay_reg;
        g2_2   = gmag2_reg * gmag2_reg;
        regp2  = reg_strength_reg * wm2_reg;
    end

    // stage 3: gradient products
    logic [31:0] w3_reg;
    logic [30:0] gcm3_reg;
    logic        gneg3_reg, clip3_reg;
    logic [15:0] regm3_reg;
    logic [47:0] pch3_reg;
    logic [63:0] pcl3_reg, g2_3_reg;
    logic [32:0] f3;
    logic [64:0] pgh3, pgl3;
    logic [48:0] t1_3;

    always_ff @(posedge aclk) begin
        if (en) begin
            idx3_reg  <= idx2_reg;
            w3_reg    <= w2_reg;
            gcm3_reg  <= gcm2_reg;
            gneg3_reg <= gneg2_reg;
            clip3_reg <= clip2_reg;
            regm3_reg <= regp2[63:48];
            pch3_reg  <= pch2;
            pcl3_reg  <= pcl2;
            g2_3_reg  <= g2_2;
        end
    end

    always_comb begin
        f3   = 33'h1_0000_0000 - {1'b0, decay_reg};
        pgh3 = g2_3_reg[63:32] * f3;
        pgl3 = g2_3_reg[31:0] * f3;
        t1_3 = {1'b0, pch3_reg} + {17'd0, pcl3_reg[63:32]};
    end

    // stage 4: sum of decay and gradient terms
    logic [31:0] w4_reg;
    logic [30:0] gcm4_reg;
    logic        gneg4_reg, clip4_reg;
    logic [15:0] regm4_reg;
    logic [64:0] pgh4_reg, pgl4_reg;
    logic [48:0] t1_4_reg;
    logic [64:0] t2s4;
    logic [49:0] nsum4;
    logic [CW-1:0] nc4;

    always_ff @(posedge aclk) begin
        if (en) begin
            idx4_reg  <= idx3_reg;
            w4_reg    <= w3_reg;
            gcm4_reg  <= gcm3_reg;
            gneg4_reg <= gneg3_reg;
            clip4_reg <= clip3_reg;
            regm4_reg <= regm3_reg;
            pgh4_reg  <= pgh3;
            pgl4_reg  <= pgl3;
            t1_4_reg  <= t1_3;
        end
    end

    always_comb begin
        t2s4  = pgh4_reg + {32'd0, pgl4_reg[64:32]};
        nsum4 = {1'b0, t1_4_reg} + {1'b0, t2s4[64:16]};
        nc4   = (nsum4[49:48] != 2'd0) ? '1 : nsum4[47:0];
    end

    // stage 5: new cache value, write-back, root operand
    logic [31:0] w5_reg;
    logic [30:0] gcm5_reg;
    logic        gneg5_reg, clip5_reg;
    logic [15:0] regm5_reg;
    logic [48:0] xsum5;
    logic [SQ_IN_W-1:0] x5;
    logic [62:0] nprod5;
    sq_pl_t      pl5;

    always_ff @(posedge aclk) begin
        if (en) begin
            idx5_reg  <= idx4_reg;
            nc5_reg   <= nc4;
            w5_reg    <= w4_reg;
            gcm5_reg  <= gcm4_reg;
            gneg5_reg <= gneg4_reg;
            clip5_reg <= clip4_reg;
            regm5_reg <= regm4_reg;
        end
    end

    always_comb begin
        xsum5   = {1'b0, nc5_reg} + {33'd0, epsilon_reg};
        x5      = {1'b0, xsum5, 14'd0};
        nprod5  = learn_rate_reg * gcm5_reg;
        pl5.w    = w5_reg;
        pl5.gneg = gneg5_reg;
        pl5.clip = clip5_reg;
        pl5.regm = regm5_reg;
        pl5.nq   = nprod5[62:9];
    end

    // square-root stages
    logic               sq_v_reg   [SQ_N];
    rwu_pkg::sq_acc_t   sq_acc_reg [SQ_N];
    logic [SQ_IN_W-1:0] sq_x_reg   [SQ_N];
    sq_pl_t             sq_pl_reg  [SQ_N];

    for (genvar j = 0; j < SQ_N; j++) begin : g_sq
        logic               v_i;
        rwu_pkg::sq_acc_t   acc_i;
        rwu_pkg::sq_acc_t   acc_next;
        logic [SQ_IN_W-1:0] x_i;
        sq_pl_t             pl_i;

        if (j == 0) begin : g_src
            assign v_i   = v5_reg;
            assign acc_i = '0;
            assign x_i   = x5;
            assign pl_i  = pl5;
        end else begin : g_src
            assign v_i   = sq_v_reg[j-1];
            assign acc_i = sq_acc_reg[j-1];
            assign x_i   = sq_x_reg[j-1];
            assign pl_i  = sq_pl_reg[j-1];
        end

        always_comb begin
            acc_next = acc_i;
            for (int k = 0; k < rwu_pkg::SQ_STEPS; k++) begin
                acc_next = rwu_pkg::sq_step(acc_next, x_i[SQ_IN_W-1-2*k -: 2]);
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                sq_v_reg[j] <= 1'b0;
            end else if (en) begin
                sq_v_reg[j] <= v_i;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                sq_acc_reg[j] <= acc_next;
                sq_x_reg[j]   <= x_i << (2 * rwu_pkg::SQ_STEPS);
                sq_pl_reg[j]  <= pl_i;
            end
        end
    end

    // divide setup: root forced to at least one, overflow check on the top bits
    logic [ROOT_W-1:0] dvs_in;
    logic              ovf_in;
    dv_pl_t            dpl_in;
    rwu_pkg::dv_acc_t  dacc_in;

    always_comb begin
        dvs_in = (sq_acc_reg[SQ_N-1].root == '0) ? ROOT_W'(1) : sq_acc_reg[SQ_N-1].root;
        ovf_in = ROOT_W'(sq_pl_reg[SQ_N-1].nq[NQ_W-1:STEP_W]) >= dvs_in;
        dacc_in.rem = ovf_in ? '0 : ROOT_W'(sq_pl_reg[SQ_N-1].nq[NQ_W-1:STEP_W]);
        dacc_in.quo = '0;
        dpl_in.w    = sq_pl_reg[SQ_N-1].w;
        dpl_in.gneg = sq_pl_reg[SQ_N-1].gneg;
        dpl_in.clip = sq_pl_reg[SQ_N-1].clip;
        dpl_in.regm = sq_pl_reg[SQ_N-1].regm;
        dpl_in.dvs  = dvs_in;
        dpl_in.ovf  = ovf_in;
    end

    // divide stages
    logic              dv_v_reg    [DV_N];
    rwu_pkg::dv_acc_t  dv_acc_reg  [DV_N];
    logic [STEP_W-1:0] dv_bits_reg [DV_N];
    dv_pl_t            dv_pl_reg   [DV_N];

    for (genvar j = 0; j < DV_N; j++) begin : g_dv
        logic              v_i;
        rwu_pkg::dv_acc_t  acc_i;
        rwu_pkg::dv_acc_t  acc_next;
        logic [STEP_W-1:0] bits_i;
        dv_pl_t            pl_i;

        if (j == 0) begin : g_src
            assign v_i    = sq_v_reg[SQ_N-1];
            assign acc_i  = dacc_in;
            assign bits_i = sq_pl_reg[SQ_N-1].nq[STEP_W-1:0];
            assign pl_i   = dpl_in;
        end else begin : g_src
            assign v_i    = dv_v_reg[j-1];
            assign acc_i  = dv_acc_reg[j-1];
            assign bits_i = dv_bits_reg[j-1];
            assign pl_i   = dv_pl_reg[j-1];
        end

        always_comb begin
            acc_next = acc_i;
            for (int k = 0; k < rwu_pkg::DV_STEPS; k++) begin
                acc_next = rwu_pkg::dv_step(acc_next, pl_i.dvs, bits_i[STEP_W-1-k]);
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_v_reg[j] <= 1'b0;
            end else if (en) begin
                dv_v_reg[j] <= v_i;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                dv_acc_reg[j]  <= acc_next;
                dv_bits_reg[j] <= bits_i << rwu_pkg::DV_STEPS;
                dv_pl_reg[j]   <= pl_i;
            end
        end
    end

    // weight result with saturation
    logic [STEP_W-1:0] stepm;
    logic [35:0]       wext, stepx, regx, res;
    logic [31:0]       wres;
    logic [32:0]       res_word;

    always_comb begin
        stepm = dv_pl_reg[DV_N-1].ovf ? '1 : dv_acc_reg[DV_N-1].quo;
        wext  = {{4{dv_pl_reg[DV_N-1].w[31]}}, dv_pl_reg[DV_N-1].w};
        stepx = {2'b00, stepm};
        regx  = {20'd0, dv_pl_reg[DV_N-1].regm};
        res   = wext + (dv_pl_reg[DV_N-1].gneg ? stepx : (~stepx + 36'd1))
                     + (dv_pl_reg[DV_N-1].w[31] ? regx : (~regx + 36'd1));
        if (!res[35] && res[34:31] != 4'h0) begin
            wres = 32'h7FFF_FFFF;
        end else if (res[35] && res[34:31] != 4'hF) begin
            wres = 32'h8000_0000;
        end else begin
            wres = res[31:0];
        end
        res_word = {dv_pl_reg[DV_N-1].clip, wres};
    end

    // two-entry output buffer
    logic        push, pop;
    logic [32:0] o0_reg, o1_reg;

    assign push = en && dv_v_reg[DV_N-1];
    assign pop  = (ocnt_reg != 2'd0) && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ocnt_reg <= 2'd0;
        end else begin
            ocnt_reg <= ocnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge aclk) begin
        if (push && (ocnt_reg == 2'd0 || (ocnt_reg == 2'd1 && pop))) begin
            o0_reg <= res_word;
        end else if (pop) begin
            o0_reg <= o1_reg;
        end
        if (push && ocnt_reg == 2'd1 && !pop) begin
            o1_reg <= res_word;
        end
    end

    assign m_tvalid   = (ocnt_reg != 2'd0);
    assign m_tdata    = o0_reg[31:0];
    assign m_tuser[0] = o0_reg[32];

endmodule

// ===== tb/rmsprop_weight_update_tb.sv =====
// Testbench for rmsprop_weight_update: random and directed element beats checked against a predictor.
class weight_scoreboard;
    logic [47:0] sq_cache [4096];
    logic [31:0] lr, dcy, rs;
    logic [30:0] clip;
    logic [15:0] eps;
    logic [31:0] exp_w [$];
    logic        exp_c [$];
    int          errors;

    function void init();
        foreach (sq_cache[i]) sq_cache[i] = '0;
        lr = rwu_pkg::LEARN_RATE_RST;
        dcy = rwu_pkg::DECAY_RST;
        clip = rwu_pkg::CLIP_LIMIT_RST;
        rs = rwu_pkg::REG_STRENGTH_RST;
        eps = rwu_pkg::EPSILON_RST;
        errors = 0;
    endfunction

    function void set_reg(rwu_pkg::reg_addr_t a, logic [31:0] v);
        case (a)
            rwu_pkg::REG_LEARN_RATE:   lr = v;
            rwu_pkg::REG_DECAY:        dcy = v;
            rwu_pkg::REG_CLIP_LIMIT:   clip = v[30:0];
            rwu_pkg::REG_REG_STRENGTH: rs = v;
            rwu_pkg::REG_EPSILON:      eps = v[15:0];
            default: ;
        endcase
    endfunction

    static function logic [63:0] root64(logic [63:0] x);
        logic [63:0] res, bit_v;
        res = 0;
        bit_v = 64'd1 << 62;
        while (bit_v > x) bit_v >>= 2;
        while (bit_v != 0) begin
            if (x >= res + bit_v) begin
                x = x - (res + bit_v);
                res = (res >> 1) + bit_v;
            end else begin
                res = res >> 1;
            end
            bit_v >>= 2;
        end
        return res;
    endfunction

    function void note_input(logic [11:0] idx, logic signed [31:0] w, logic signed [31:0] g,
                             logic fresh);
        logic [47:0] c;
        logic [63:0] gm, g2, wm, gcm, r, stepm, regm;
        logic [127:0] t1, t2, nc;
        logic signed [63:0] gc, lim, res;
        logic clipped;
        c = fresh ? 48'd0 : sq_cache[idx];
        gm = (g < 0) ? 64'(-64'(g)) : 64'(g);
        g2 = gm * gm;
        t1 = (128'(c) * 128'(dcy)) >> 32;
        t2 = (128'(g2) * (128'd1 << 32) - 128'(g2) * 128'(dcy)) >> 48;
        nc = t1 + t2;
        if (nc > 128'h0000_FFFF_FFFF_FFFF) nc = 128'h0000_FFFF_FFFF_FFFF;
        sq_cache[idx] = nc[47:0];
        lim = 64'(clip);
        gc = 64'(g);
        clipped = 0;
        if (gc > lim) begin
            gc = lim; clipped = 1;
        end else if (gc < -lim) begin
            gc = -lim; clipped = 1;
        end
        r = root64((64'(nc[47:0]) + 64'(eps)) << 14);
        if (r == 0) r = 1;
        gcm = (gc < 0) ? 64'(-gc) : 64'(gc);
        stepm = (64'(lr) * gcm) / (r << 9);
        wm = (w < 0) ? 64'(-64'(w)) : 64'(w);
        regm = 64'((128'(rs) * 128'(wm)) >> 48);
        res = 64'(w);
        res = res + ((gc < 0) ? $signed(stepm) : -$signed(stepm));
        res = res + ((w < 0) ? $signed(regm) : -$signed(regm));
        if (res > 64'sd2147483647) res = 64'sd2147483647;
        if (res < -64'sd2147483648) res = -64'sd2147483648;
        exp_w.push_back(res[31:0]);
        exp_c.push_back(clipped);
    endfunction

    function void check_result(logic [31:0] w, logic c);
        logic [31:0] ew;
        logic ec;
        if (exp_w.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result beat w=%h c=%b", w, c);
            return;
        end
        ew = exp_w.pop_front();
        ec = exp_c.pop_front();
        if (ew !== w || ec !== c) begin
            errors++;
            if (errors <= 10)
                $display("result mismatch: expected w=%h c=%b, got w=%h c=%b", ew, ec, w, c);
        end
    endfunction
endclass

module rmsprop_weight_update_tb;

    logic aclk = 0, aresetn = 0;
    logic s_tvalid = 0, s_tready;
    logic [79:0] s_tdata = '0;
    logic [0:0] s_tuser = '0;
    logic m_tvalid, m_tready = 0;
    logic [31:0] m_tdata;
    logic [0:0] m_tuser;
    logic psel = 0, penable = 0, pwrite = 0;
    logic [4:0] paddr = '0;
    logic [31:0] pwdata = '0, prdata;
    logic pready;

    weight_scoreboard sb;
    int idle_cycles = 0;
    bit hold_sink = 0;
    bit sink_run = 0;
    logic [11:0] last_idx = 0;

    rmsprop_weight_update dut (.*);

    always begin
        #4 aclk = 1;
        #4 aclk = 0;
    end

    function automatic int gap_len();
        if ($urandom_range(0, 3) == 0) return 0;
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
        return $urandom_range(0, 3);
    endfunction

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready)
            sb.note_input(s_tdata[11:0], s_tdata[43:12], s_tdata[75:44], s_tuser[0]);
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tuser[0]);
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel || !aresetn ||
            hold_sink) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // result-side ready with random stalls
    initial begin
        int n;
        wait (sink_run);
        forever begin
            @(negedge aclk);
            if (hold_sink) begin
                m_tready <= 0;
            end else begin
                n = gap_len();
                if (n == 0) begin
                    m_tready <= 1;
                end else begin
                    m_tready <= 0;
                    repeat (n - 1) @(negedge aclk);
                end
            end
        end
    end

    task automatic apb_write(rwu_pkg::reg_addr_t a, logic [31:0] v);
        @(negedge aclk);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= 5'(a) << 2; pwdata <= v;
        @(negedge aclk);
        penable <= 1;
        @(posedge aclk);
        sb.set_reg(a, v);
        @(negedge aclk);
        psel <= 0; penable <= 0; pwrite <= 0;
    endtask

    task automatic send_beat(logic [11:0] idx, logic [31:0] w, logic [31:0] g, logic f);
        s_tvalid <= 1;
        s_tdata <= {4'd0, g, w, idx};
        s_tuser <= f;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic send_random(bit gaps);
        logic [11:0] idx;
        logic [31:0] w, g;
        int k, n;
        k = $urandom_range(0, 9);
        idx = (k < 3) ? last_idx : (k < 5) ? 12'($urandom_range(0, 15)) : 12'($urandom);
        last_idx = idx;
        w = $urandom;
        if ($urandom_range(0, 1)) w = $signed(w) >>> $urandom_range(0, 24);
        g = $urandom;
        if ($urandom_range(0, 2)) g = $signed(g) >>> $urandom_range(0, 28);
        send_beat(idx, w, g, $urandom_range(0, 7) == 0);
        if (gaps) begin
            n = gap_len();
            if (n > 0) begin
                s_tvalid <= 0;
                repeat (n) @(negedge aclk);
            end
        end
    endtask

    task automatic drain();
        s_tvalid <= 0;
        while (sb.exp_w.size() != 0) @(negedge aclk);
        repeat (60) @(negedge aclk);
    endtask

    task automatic write_all(logic [31:0] lr, logic [31:0] dc, logic [31:0] cl,
                             logic [31:0] rg, logic [31:0] ep);
        apb_write(rwu_pkg::REG_LEARN_RATE, lr);
        apb_write(rwu_pkg::REG_DECAY, dc);
        apb_write(rwu_pkg::REG_CLIP_LIMIT, cl);
        apb_write(rwu_pkg::REG_REG_STRENGTH, rg);
        apb_write(rwu_pkg::REG_EPSILON, ep);
    endtask

    initial begin
        sb = new();
        sb.init();
        repeat (10) @(negedge aclk);
        aresetn <= 1;
        sink_run = 1;
        @(negedge aclk);
        // directed: field extremes, clipping both ways, zero root, same-index chains
        send_beat(12'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
        send_beat(12'd0, 32'h8000_0000, 32'h8000_0000, 0);
        send_beat(12'hFFF, 32'h0, 32'h0, 1);
        send_beat(12'hFFF, 32'h0100_0000, 32'h0500_0000, 0);
        send_beat(12'hFFF, 32'hFF00_0000, 32'hFAFF_FFFF, 0);
        send_beat(12'd5, 32'h0, 32'h0500_0001, 0);
        send_beat(12'd5, 32'hFFFF_FFFF, 32'h1, 1);
        send_beat(12'd6, 32'h1234_5678, 32'hFFFF_FFFF, 0);
        drain();
        write_all(32'hFFFF_FFFF, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'h0);
        send_beat(12'd7, 32'h7FFF_FFFF, 32'h0, 0);
        send_beat(12'd7, 32'h8000_0000, 32'h8000_0000, 0);
        send_beat(12'd8, 32'h4000_0000, 32'h0000_0001, 1);
        send_beat(12'd8, 32'hC000_0000, 32'hFFFF_FFFF, 0);
        drain();
        write_all(32'h0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h0, 32'hFFFF);
        send_beat(12'd9, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
        send_beat(12'd9, 32'h8000_0000, 32'h8000_0000, 0);
        drain();
        write_all(rwu_pkg::LEARN_RATE_RST, rwu_pkg::DECAY_RST, rwu_pkg::CLIP_LIMIT_RST,
                  rwu_pkg::REG_STRENGTH_RST, rwu_pkg::EPSILON_RST);
        // random phases with several settings
        for (int ph = 0; ph < 4; ph++) begin
            if (ph > 0)
                write_all($urandom, $urandom, $urandom, $urandom, $urandom);
            if (ph == 2) begin
                fork
                    begin
                        hold_sink = 1;
                        repeat (300) @(negedge aclk);
                        hold_sink = 0;
                    end
                    for (int i = 0; i < 60; i++) send_random(0);
                join
            end
            for (int i = 0; i < 135; i++) send_random(1);
            drain();
        end
        if (sb.errors == 0 && sb.exp_w.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
